// ----- src/bilinear_image_resampler_top_assert.svh -----
`ifndef BILINEAR_IMAGE_RESAMPLER_TOP_ASSERT_SVH
`define BILINEAR_IMAGE_RESAMPLER_TOP_ASSERT_SVH
// implication check under synchronous reset
`define BIR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bir assertion failed");
// next-cycle implication check
`define BIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bir assertion failed");
`endif

// ----- src/bir_pkg.sv -----
`default_nettype none
package bir_pkg;
  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int FracBits = 16;
  localparam int DimW = 9;
  localparam int AddrW = 16;
  localparam int Depth = MaxWidth * MaxHeight;
  localparam int PixW = 32;
  localparam int CoordW = 8;
  localparam int RecipK = 40;
  localparam int RecipW = RecipK + 1;

  localparam logic [1:0] RegSrcW = 2'd0;
  localparam logic [1:0] RegSrcH = 2'd1;
  localparam logic [1:0] RegDstW = 2'd2;
  localparam logic [1:0] RegDstH = 2'd3;
  localparam logic OpLoad = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] src_w;
    logic [DimW-1:0] src_h;
    logic [DimW-1:0] dst_w;
    logic [DimW-1:0] dst_h;
  } cfg_t;

  // ceil(2^40 / d) for d in 1..256 gives exact floor(n/d) for n < 2^32
  function automatic logic [RecipW-1:0] recip(input logic [DimW-1:0] d);
    logic [RecipW-1:0] q;
    q = '0;
    for (int k = 1; k <= MaxWidth; k++) begin
      if (d == DimW'(k)) q = RecipW'(((64'd1 << RecipK) + 64'(k) - 64'd1) / 64'(k));
    end
    return q;
  endfunction
endpackage
`default_nettype wire

// ----- src/bilinear_image_resampler_top.sv -----
`default_nettype none
// Bilinear resampler. A load beat (op 0) writes one RGBA word into a 64K-word
// source store; a sample beat (op 1) returns one interpolated pixel with
// out_valid high for one cycle, after 3 address stages, 1 store read, 3 blend
// stages and an output register. start is taken every cycle (busy stays low);
// the receiver cannot stall, so there is no backpressure. The store is four
// replicated RAMs, one per neighbor, so one sample per cycle. Store writes
// pass through three delay registers so loads and samples keep order.
module bilinear_image_resampler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [15:0] in_load_addr,
  input  wire logic [31:0] in_load_pixel,
  input  wire logic [7:0]  in_dst_x,
  input  wire logic [7:0]  in_dst_y,
  output logic             out_valid,
  output logic [31:0]      out_pixel,
  output logic [7:0]       out_x,
  output logic [7:0]       out_y,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import bir_pkg::*;
  `include "bilinear_image_resampler_top_assert.svh"
  cfg_t cfg_r;
  logic [DimW-1:0] cv;
  logic go, av, rv_r, bv;
  logic [7:0] ax, ay, rx_r, ry_r, bx, by;
  logic [15:0] au, avv, ru_r, rv2_r, a0, a1, a2, a3;
  logic [31:0] d0, d1, d2, d3, bp;
  logic out_valid_r;
  logic [31:0] out_pixel_r;
  logic [7:0] out_x_r, out_y_r;
  logic [2:0] wv_r;
  logic [15:0] wa1_r, wa2_r, wa3_r;
  logic [31:0] wd1_r, wd2_r, wd3_r;

  assign busy = 1'b0;
  assign go = start && !busy;
  assign cv = (cfg_data == '0) ? 9'd1 : ((cfg_data > 9'd256) ? 9'd256 : cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{9'd256, 9'd256, 9'd256, 9'd256};
    end else if (cfg_we) begin
      case (cfg_index)
        RegSrcW: cfg_r.src_w <= cv;
        RegSrcH: cfg_r.src_h <= cv;
        RegDstW: cfg_r.dst_w <= cv;
        RegDstH: cfg_r.dst_h <= cv;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  bir_addr u_addr (
    .clk, .rst_n, .cfg(cfg_r), .vld(go && in_op == OpSample), .x(in_dst_x), .y(in_dst_y),
    .vld_o(av), .x_o(ax), .y_o(ay), .u_o(au), .v_o(avv),
    .a0_o(a0), .a1_o(a1), .a2_o(a2), .a3_o(a3)
  );

  logic we;
  assign we = go && in_op == OpLoad;

  always_ff @(posedge clk) begin
    if (!rst_n) wv_r <= '0;
    else wv_r <= {wv_r[1:0], we};
    wa1_r <= in_load_addr; wa2_r <= wa1_r; wa3_r <= wa2_r;
    wd1_r <= in_load_pixel; wd2_r <= wd1_r; wd3_r <= wd2_r;
  end

  bir_ram #(.Width(PixW), .Depth(Depth)) u_ram0 (.clk, .we(wv_r[2]), .waddr(wa3_r),
    .wdata(wd3_r), .raddr(a0), .rdata(d0));
  bir_ram #(.Width(PixW), .Depth(Depth)) u_ram1 (.clk, .we(wv_r[2]), .waddr(wa3_r),
    .wdata(wd3_r), .raddr(a1), .rdata(d1));
  bir_ram #(.Width(PixW), .Depth(Depth)) u_ram2 (.clk, .we(wv_r[2]), .waddr(wa3_r),
    .wdata(wd3_r), .raddr(a2), .rdata(d2));
  bir_ram #(.Width(PixW), .Depth(Depth)) u_ram3 (.clk, .we(wv_r[2]), .waddr(wa3_r),
    .wdata(wd3_r), .raddr(a3), .rdata(d3));

  always_ff @(posedge clk) begin
    if (!rst_n) rv_r <= 1'b0;
    else rv_r <= av;
    rx_r <= ax; ry_r <= ay; ru_r <= au; rv2_r <= avv;
  end

  bir_blend u_blend (
    .clk, .rst_n, .vld(rv_r), .x(rx_r), .y(ry_r), .u(ru_r), .v(rv2_r),
    .p0(d0), .p1(d1), .p2(d2), .p3(d3),
    .vld_o(bv), .x_o(bx), .y_o(by), .pix_o(bp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= bv;
    out_pixel_r <= bp; out_x_r <= bx; out_y_r <= by;
  end
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;

  `BIR_ASSERT_NEXT(a_ram_valid, av, rv_r)
  `BIR_ASSERT_NEXT(a_out_follows, bv, out_valid)
  `BIR_ASSERT_IMP(a_cfg_range, 1'b1, cfg_r.src_w != '0 && cfg_r.dst_w != '0)
endmodule
`default_nettype wire

// ----- src/bir_ram.sv -----
`default_nettype none
module bir_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/bir_addr.sv -----
`default_nettype none
module bir_addr (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bir_pkg::cfg_t          cfg,
  input  wire logic                   vld,
  input  wire logic [7:0]             x,
  input  wire logic [7:0]             y,
  output logic                        vld_o,
  output logic [7:0]                  x_o,
  output logic [7:0]                  y_o,
  output logic [15:0]                 u_o,
  output logic [15:0]                 v_o,
  output logic [15:0]                 a0_o,
  output logic [15:0]                 a1_o,
  output logic [15:0]                 a2_o,
  output logic [15:0]                 a3_o
);
  import bir_pkg::*;
  logic [2:0] vld_r;
  logic [7:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [15:0] nx_r, ny_r;
  logic [RecipW-1:0] rx_r, ry_r;
  logic [56:0] qx_r, qy_r;
  logic [24:0] base_r, last_r;
  logic [15:0] u3_r, v3_r;
  logic [24:0] i0, i1, i2, i3, last;

  assign last = 25'(cfg.src_w) * 25'(cfg.src_h) - 25'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[1:0], vld};
    nx_r <= 16'(x) * 16'(cfg.src_w);
    ny_r <= 16'(y) * 16'(cfg.src_h);
    rx_r <= recip(cfg.dst_w);
    ry_r <= recip(cfg.dst_h);
    x1_r <= x; y1_r <= y;
    qx_r <= 57'(nx_r) * 57'(rx_r);
    qy_r <= 57'(ny_r) * 57'(ry_r);
    x2_r <= x1_r; y2_r <= y1_r;
    u3_r <= qx_r[39:24];
    v3_r <= qy_r[39:24];
    base_r <= 25'(qx_r[55:40]) + 25'(qy_r[55:40]) * 25'(cfg.src_w);
    last_r <= last;
    x3_r <= x2_r; y3_r <= y2_r;
  end

  always_comb begin
    i0 = base_r;
    i1 = base_r + 25'd1;
    i2 = base_r + 25'(cfg.src_w);
    i3 = i2 + 25'd1;
    a0_o = 16'((i0 > last_r) ? last_r : i0);
    a1_o = 16'((i1 > last_r) ? last_r : i1);
    a2_o = 16'((i2 > last_r) ? last_r : i2);
    a3_o = 16'((i3 > last_r) ? last_r : i3);
  end
  assign vld_o = vld_r[2];
  assign x_o = x3_r;
  assign y_o = y3_r;
  assign u_o = u3_r;
  assign v_o = v3_r;
endmodule
`default_nettype wire

// ----- src/bir_blend.sv -----
`default_nettype none
module bir_blend (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        vld,
  input  wire logic [7:0]  x,
  input  wire logic [7:0]  y,
  input  wire logic [15:0] u,
  input  wire logic [15:0] v,
  input  wire logic [31:0] p0,
  input  wire logic [31:0] p1,
  input  wire logic [31:0] p2,
  input  wire logic [31:0] p3,
  output logic             vld_o,
  output logic [7:0]       x_o,
  output logic [7:0]       y_o,
  output logic [31:0]      pix_o
);
  import bir_pkg::*;
  logic [2:0] vld_r;
  logic [7:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [32:0] w0_r, w1_r, w2_r, w3_r;
  logic [31:0] q0_r, q1_r, q2_r, q3_r;
  logic [31:0] pix_r;
  logic [16:0] su, sv;
  logic [42:0] m0 [4], m1 [4], m2 [4], m3 [4];
  logic [42:0] s0_r [4], s1_r [4];

  assign su = 17'h10000 - 17'(u);
  assign sv = 17'h10000 - 17'(v);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      m0[c] = 43'(w0_r) * 43'(q0_r[8*c +: 8]);
      m1[c] = 43'(w1_r) * 43'(q1_r[8*c +: 8]);
      m2[c] = 43'(w2_r) * 43'(q2_r[8*c +: 8]);
      m3[c] = 43'(w3_r) * 43'(q3_r[8*c +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[1:0], vld};
    w0_r <= 33'(su) * 33'(sv);
    w1_r <= 33'(u) * 33'(sv);
    w2_r <= 33'(su) * 33'(v);
    w3_r <= 33'(u) * 33'(v);
    q0_r <= p0; q1_r <= p1; q2_r <= p2; q3_r <= p3;
    x1_r <= x; y1_r <= y;
    for (int c = 0; c < 4; c++) begin
      s0_r[c] <= m0[c] + m1[c];
      s1_r[c] <= m2[c] + m3[c];
      pix_r[8*c +: 8] <= 8'((s0_r[c] + s1_r[c]) >> (2*FracBits));
    end
    x2_r <= x1_r; y2_r <= y1_r;
    x3_r <= x2_r; y3_r <= y2_r;
  end
  assign vld_o = vld_r[2];
  assign x_o = x3_r;
  assign y_o = y3_r;
  assign pix_o = pix_r;
endmodule
`default_nettype wire

// ----- bench/bilinear_image_resampler_top_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module bilinear_image_resampler_top_tb;
  import bir_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 16;

  typedef struct {
    logic [31:0] pixel;
    logic [7:0]  x;
    logic [7:0]  y;
  } blend_t;

  typedef struct {
    logic        op;
    logic [15:0] addr;
    logic [31:0] pix;
    logic [7:0]  x;
    logic [7:0]  y;
    bit          known;
    logic [31:0] want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = OpLoad;
  logic [15:0] in_load_addr = '0;
  logic [31:0] in_load_pixel = '0;
  logic [7:0]  in_dst_x = '0;
  logic [7:0]  in_dst_y = '0;
  logic        out_valid;
  logic [31:0] out_pixel;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = RegSrcW;
  logic [8:0]  cfg_data = '0;

  logic [31:0] image_mem [0:Depth-1];
  int unsigned src_w = 256, src_h = 256, dst_w = 256, dst_h = 256;
  blend_t      pending_q[$];
  int unsigned mismatches = 0, items = 0, samples = 0, matched = 0, cycles = 0;
  int unsigned idle_pct = 0, phases = 0;

  bilinear_image_resampler_top uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [8:0] raw);
    int unsigned v;
    v = raw;
    if (v < 1) v = 1;
    if (v > MaxWidth) v = MaxWidth;
    return v;
  endfunction

  function automatic logic [31:0] blend_pixel(logic [7:0] x, logic [7:0] y);
    longint unsigned one, px, py, u, v, acc;
    longint unsigned w [4];
    int unsigned ix, iy, base, last, idx;
    logic [31:0] nb [4];
    logic [31:0] res;
    one = 64'd1 << FracBits;
    px = ((longint'(x) * src_w) << FracBits) / dst_w;
    py = ((longint'(y) * src_h) << FracBits) / dst_h;
    ix = px >> FracBits;
    iy = py >> FracBits;
    u = px & (one - 1);
    v = py & (one - 1);
    last = src_w * src_h - 1;
    base = ix + iy * src_w;
    for (int k = 0; k < 4; k++) begin
      idx = base + ((k & 1) ? 1 : 0) + ((k & 2) ? src_w : 0);
      if (idx > last) idx = last;
      nb[k] = image_mem[idx];
    end
    w[0] = (one - u) * (one - v);
    w[1] = u * (one - v);
    w[2] = (one - u) * v;
    w[3] = u * v;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += w[k] * nb[k][ch*8 +: 8];
      res[ch*8 +: 8] = 8'(acc >> (2 * FracBits));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    blend_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: pixel %h at (%0d,%0d)", out_pixel, out_x, out_y);
      end else begin
        e = pending_q.pop_front();
        if (out_pixel !== e.pixel || out_x !== e.x || out_y !== e.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %h (%0d,%0d) got %h (%0d,%0d)",
                     e.pixel, e.x, e.y, out_pixel, out_x, out_y);
        end else begin
          matched++;
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send(logic op, logic [15:0] addr, logic [31:0] pix,
                      logic [7:0] x, logic [7:0] y);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_op = op;
    in_load_addr = addr;
    in_load_pixel = pix;
    in_dst_x = x;
    in_dst_y = y;
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
    if (op == OpLoad) begin
      image_mem[addr] = pix;
    end else begin
      samples++;
      pending_q.push_back('{blend_pixel(x, y), x, y});
    end
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegSrcW: src_w = clamp_dim(data);
      RegSrcH: src_h = clamp_dim(data);
      RegDstW: dst_w = clamp_dim(data);
      default: dst_h = clamp_dim(data);
    endcase
  endtask

  task automatic set_sizes(logic [8:0] sw, logic [8:0] sh, logic [8:0] dw, logic [8:0] dh);
    drain();
    write_reg(RegSrcW, sw);
    write_reg(RegSrcH, sh);
    write_reg(RegDstW, dw);
    write_reg(RegDstH, dh);
  endtask

  row_t rows [] = '{
    '{OpLoad,   16'd0,     32'hFFFF_FFFF, 8'd0,   8'd0,   1'b0, 32'h0},
    '{OpSample, 16'd0,     32'h0,         8'd0,   8'd0,   1'b1, 32'hFFFF_FFFF},
    '{OpSample, 16'hFFFF,  32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1, 32'hFFFF_FFFF},
    '{OpLoad,   16'd0,     32'h0,         8'd0,   8'd0,   1'b0, 32'h0},
    '{OpSample, 16'd0,     32'h0,         8'd128, 8'd7,   1'b1, 32'h0},
    '{OpLoad,   16'hFFFF,  32'h1234_5678, 8'd0,   8'd0,   1'b0, 32'h0},
    '{OpLoad,   16'h8000,  32'h8765_4321, 8'd0,   8'd0,   1'b0, 32'h0},
    '{OpLoad,   16'd0,     32'hA5C3_0F81, 8'd0,   8'd0,   1'b0, 32'h0},
    '{OpSample, 16'd0,     32'h0,         8'd255, 8'd0,   1'b1, 32'hA5C3_0F81},
    '{OpSample, 16'd0,     32'h0,         8'd0,   8'd255, 1'b1, 32'hA5C3_0F81},
    '{OpLoad,   16'd1,     32'h0000_FF00, 8'd0,   8'd0,   1'b0, 32'h0},
    '{OpSample, 16'd0,     32'h0,         8'd1,   8'd1,   1'b0, 32'h0}
  };

  initial begin
    logic [8:0] sw, sh, dw, dh;
    int unsigned npix, mode;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // 1x1 source via zero writes, destination via oversize writes
    write_reg(RegSrcW, 9'd0);
    write_reg(RegSrcH, 9'd0);
    write_reg(RegDstW, 9'h1FF);
    write_reg(RegDstH, 9'h1FF);
    foreach (rows[i]) begin
      if (rows[i].known) begin
        if (blend_pixel(rows[i].x, rows[i].y) !== rows[i].want) begin
          mismatches++;
          $display("table row %0d: predictor disagrees with %h", i, rows[i].want);
        end
      end
      send(rows[i].op, rows[i].addr, rows[i].pix, rows[i].x, rows[i].y);
    end

    while (items < 1950 || phases < 8) begin
      mode = phases % 4;
      case (phases)
        0: begin sw = 9'd256; sh = 9'd1;   dw = 9'd256; dh = 9'd1; end
        1: begin sw = 9'd1;   sh = 9'd256; dw = 9'd1;   dh = 9'd256; end
        2: begin sw = 9'h1FF; sh = 9'd2;   dw = 9'd3;   dh = 9'd255; end
        3: begin sw = 9'd5;   sh = 9'd4;   dw = 9'd0;   dh = 9'd0; end
        default: begin
          sw = $urandom_range(1, 12);
          sh = $urandom_range(1, 12);
          dw = ($urandom_range(9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 24));
          dh = ($urandom_range(9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 24));
        end
      endcase
      set_sizes(sw, sh, dw, dh);
      idle_pct = (mode == 1) ? 66 : (mode == 3) ? 8 : 0;
      npix = src_w * src_h;
      for (int i = 0; i < npix; i++) send(OpLoad, 16'(i), $urandom, 8'd0, 8'd0);
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(9) == 0)
          send(OpLoad, ($urandom_range(1) ? 16'($urandom_range(npix - 1)) : 16'($urandom)),
               $urandom, 8'($urandom), 8'($urandom));
        else if ($urandom_range(4) == 0)
          send(OpSample, 16'($urandom), $urandom, 8'($urandom), 8'($urandom));
        else
          send(OpSample, 16'($urandom), $urandom,
               8'($urandom_range(0, (dst_w + 1 > 255) ? 255 : dst_w + 1)),
               8'($urandom_range(0, (dst_h + 1 > 255) ? 255 : dst_h + 1)));
      end
      phases++;
    end
    drain();

    $display("%0d beats sent (%0d samples) over %0d size settings, %0d results matched",
             items, samples, phases + 1, matched);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
